### rtl/core/nfaer_pkg.sv
package nfaer_pkg;

	// Default table geometry.
	localparam int MAX_STATES_DEF  = 16;
	localparam int MAX_SYMBOLS_DEF = 4;

	// Field and register widths.
	localparam int MODE_W    = 3;
	localparam int NS_W      = 5;
	localparam int NA_W      = 3;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;

	// Item operation codes.
	localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADD_SYM = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ADD_EPS = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FINAL   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_COMPUTE = 3'd4;
	localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_SYMBOLS = 1'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clear_tables;
		logic sym_wr;
		logic eps_wr;
		logic fin_wr;
		logic set_err;
		logic q_capture;
		logic warsh_init;
		logic warsh_step;
		logic fin_prop;
		logic acc_clr;
		logic reach_issue;
		logic clos_step;
		logic res_write;
		logic sym_next;
		logic done_compute;
		logic out_load;
	} nfaer_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              item_ok;
		logic              last_step;
		logic              last_sym;
	} nfaer_sts_t;

endpackage

### rtl/core/nfaer_ram.sv
module nfaer_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/nfaer_ctrl.sv
module nfaer_ctrl
	import nfaer_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	output nfaer_cmd_t cmd,
	input  nfaer_sts_t sts
);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_DECODE    = 4'd1;
	localparam logic [3:0] ST_SYM_WR    = 4'd2;
	localparam logic [3:0] ST_QUERY     = 4'd3;
	localparam logic [3:0] ST_WARSH     = 4'd4;
	localparam logic [3:0] ST_FPROP     = 4'd5;
	localparam logic [3:0] ST_REACH     = 4'd6;
	localparam logic [3:0] ST_REACH_END = 4'd7;
	localparam logic [3:0] ST_CLOS      = 4'd8;
	localparam logic [3:0] ST_WRITE     = 4'd9;
	localparam logic [3:0] ST_FIN       = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_FIN;
				if (!sts.item_ok) begin
					cmd.set_err = 1'b1;
				end else begin
					case (sts.mode)
						MODE_CLEAR:   cmd.clear_tables = 1'b1;
						MODE_ADD_SYM: state_d = ST_SYM_WR;
						MODE_ADD_EPS: cmd.eps_wr = 1'b1;
						MODE_FINAL:   cmd.fin_wr = 1'b1;
						MODE_COMPUTE: begin
							cmd.warsh_init = 1'b1;
							state_d        = ST_WARSH;
						end
						MODE_QUERY:   state_d = ST_QUERY;
						default:      cmd.set_err = 1'b1;
					endcase
				end
			end
			ST_SYM_WR: begin
				cmd.sym_wr = 1'b1;
				state_d    = ST_FIN;
			end
			ST_QUERY: begin
				cmd.q_capture = 1'b1;
				state_d       = ST_FIN;
			end
			ST_WARSH: begin
				cmd.warsh_step = 1'b1;
				if (sts.last_step) begin
					state_d = ST_FPROP;
				end
			end
			ST_FPROP: begin
				cmd.fin_prop = 1'b1;
				cmd.acc_clr  = 1'b1;
				state_d      = ST_REACH;
			end
			ST_REACH: begin
				cmd.reach_issue = 1'b1;
				if (sts.last_step) begin
					state_d = ST_REACH_END;
				end
			end
			ST_REACH_END: begin
				state_d = ST_CLOS;
			end
			ST_CLOS: begin
				cmd.clos_step = 1'b1;
				if (sts.last_step) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.res_write = 1'b1;
				if (sts.last_step) begin
					if (sts.last_sym) begin
						cmd.done_compute = 1'b1;
						state_d          = ST_FIN;
					end else begin
						cmd.sym_next = 1'b1;
						cmd.acc_clr  = 1'b1;
						state_d      = ST_REACH;
					end
				end
			end
			ST_FIN: begin
				if (!(out_valid_q && out_stall)) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.out_load | (out_valid_q & out_stall);
		end
	end

	// An accepted item always starts work.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_DECODE))
		else $error("accepted item did not start decode");

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("result loaded over a stalled result");

	// A finished item reaches the output once it is free.
	a_fin_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !(out_valid_q && out_stall)) |=>
		(out_valid_q && state_q == ST_IDLE))
		else $error("finished item not delivered");

	// Compute ends only on the last row of the last symbol.
	a_compute_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done_compute |-> (sts.last_step && sts.last_sym))
		else $error("compute ended before the last row and symbol");

endmodule

### rtl/core/nfaer_dp.sv
module nfaer_dp
	import nfaer_pkg::*;
#(
	parameter int MAX_STATES  = MAX_STATES_DEF,
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  nfaer_cmd_t                                        cmd,
	output nfaer_sts_t                                        sts,
	input  logic                                              cfg_we,
	input  logic [CFG_IDX_W-1:0]                              cfg_index,
	input  logic [CFG_W-1:0]                                  cfg_data,
	input  logic [MODE_W-1:0]                                 mode,
	input  logic [$clog2(MAX_STATES)-1:0]                     from_state,
	input  logic [((MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1)-1:0] symbol,
	input  logic [$clog2(MAX_STATES)-1:0]                     to_state,
	output logic                                              status,
	output logic [MAX_STATES-1:0]                             target_mask,
	output logic [MAX_STATES-1:0]                             closure_mask,
	output logic                                              is_final
);

	localparam int SW    = $clog2(MAX_STATES);
	localparam int SYW   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int DEPTH = MAX_STATES * MAX_SYMBOLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int EW    = (NS_W > $clog2(MAX_STATES + 1)) ? NS_W : $clog2(MAX_STATES + 1);
	localparam int EWA   = (NA_W > $clog2(MAX_SYMBOLS + 1)) ? NA_W : $clog2(MAX_SYMBOLS + 1);
	localparam logic [MAX_STATES-1:0] ONE = {{(MAX_STATES - 1){1'b0}}, 1'b1};

	typedef logic [MAX_STATES-1:0] row_t;

	// Table address of one state and symbol.
	function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] st,
			input logic [SYW-1:0] sy);
		addr_of = AW'(st) * AW'(MAX_SYMBOLS) + AW'(sy);
	endfunction

	// Configuration registers.
	logic [NS_W-1:0] num_states_q;
	logic [NA_W-1:0] num_symbols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q  <= NS_W'(16);
			num_symbols_q <= NA_W'(4);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_STATES:  num_states_q  <= cfg_data[NS_W-1:0];
				CFG_NUM_SYMBOLS: num_symbols_q <= cfg_data[NA_W-1:0];
				default:         ;
			endcase
		end
	end

	// Effective counts clamp to the table geometry.
	logic [EW-1:0]  ns_raw, ns_eff;
	logic [EWA-1:0] na_raw, na_eff;
	row_t           act;

	assign ns_raw = EW'(num_states_q);
	assign na_raw = EWA'(num_symbols_q);
	assign ns_eff = (ns_raw > EW'(MAX_STATES)) ? EW'(MAX_STATES) : ns_raw;
	assign na_eff = (na_raw > EWA'(MAX_SYMBOLS)) ? EWA'(MAX_SYMBOLS) : na_raw;

	// Latched item.
	logic [MODE_W-1:0] mode_q;
	logic [SW-1:0]     from_q, to_q;
	logic [SYW-1:0]    sym_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			from_q <= from_state;
			sym_q  <= symbol;
			to_q   <= to_state;
		end
	end

	// Range check of the latched item for its operation.
	logic from_ok, to_ok, sym_ok, item_ok;

	assign from_ok = EW'(from_q) < ns_eff;
	assign to_ok   = EW'(to_q) < ns_eff;
	assign sym_ok  = EWA'(sym_q) < na_eff;

	always_comb begin
		case (mode_q)
			MODE_CLEAR:   item_ok = 1'b1;
			MODE_ADD_SYM: item_ok = from_ok & to_ok & sym_ok;
			MODE_ADD_EPS: item_ok = from_ok & to_ok;
			MODE_FINAL:   item_ok = from_ok;
			MODE_COMPUTE: item_ok = 1'b1;
			MODE_QUERY:   item_ok = from_ok & sym_ok;
			default:      item_ok = 1'b0;
		endcase
	end

	// Row and symbol counters for the compute passes.
	logic [SW-1:0]  step_q;
	logic [SYW-1:0] symc_q;
	logic           last_step, last_sym, symc_ok;
	logic           step_adv;

	assign last_step = (step_q == SW'(MAX_STATES - 1));
	assign last_sym  = (symc_q == SYW'(MAX_SYMBOLS - 1));
	assign symc_ok   = EWA'(symc_q) < na_eff;
	assign step_adv  = cmd.warsh_step | cmd.reach_issue | cmd.clos_step | cmd.res_write;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			symc_q <= '0;
		end else begin
			if (cmd.warsh_init) begin
				step_q <= '0;
			end else if (step_adv) begin
				step_q <= last_step ? '0 : step_q + SW'(1);
			end
			if (cmd.warsh_init) begin
				symc_q <= '0;
			end else if (cmd.sym_next) begin
				symc_q <= symc_q + SYW'(1);
			end
		end
	end

	assign sts.mode      = mode_q;
	assign sts.item_ok   = item_ok;
	assign sts.last_step = last_step;
	assign sts.last_sym  = last_sym;

	// Symbol move table with one valid bit per entry.
	logic [AW-1:0]    item_addr, cnt_addr, sym_raddr;
	row_t             sym_rdata, sym_wdata, res_rdata;
	logic [DEPTH-1:0] sym_vld_q;
	logic             sym_vrd_q;
	row_t             sym_cur;

	assign item_addr = addr_of(from_q, sym_q);
	assign cnt_addr  = addr_of(step_q, symc_q);
	assign sym_raddr = cmd.reach_issue ? cnt_addr : item_addr;
	assign sym_cur   = sym_rdata & {MAX_STATES{sym_vrd_q}};
	assign sym_wdata = sym_cur | (ONE << to_q);

	nfaer_ram #(
		.WIDTH (MAX_STATES),
		.DEPTH (DEPTH)
	) u_sym_ram (
		.clk   (clk),
		.we    (cmd.sym_wr),
		.waddr (item_addr),
		.wdata (sym_wdata),
		.raddr (sym_raddr),
		.rdata (sym_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_vld_q <= '0;
			sym_vrd_q <= 1'b0;
		end else begin
			if (cmd.clear_tables) begin
				sym_vld_q <= '0;
			end else if (cmd.sym_wr) begin
				sym_vld_q[item_addr] <= 1'b1;
			end
			sym_vrd_q <= sym_vld_q[sym_raddr];
		end
	end

	// Result move table; queries read it only after a full compute.
	row_t res_q [MAX_STATES];
	logic computed_q;

	nfaer_ram #(
		.WIDTH (MAX_STATES),
		.DEPTH (DEPTH)
	) u_res_ram (
		.clk   (clk),
		.we    (cmd.res_write),
		.waddr (cnt_addr),
		.wdata (res_q[0]),
		.raddr (item_addr),
		.rdata (res_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			computed_q <= 1'b0;
		end else if (cmd.clear_tables) begin
			computed_q <= 1'b0;
		end else if (cmd.done_compute) begin
			computed_q <= 1'b1;
		end
	end

	// Reach stage: symbol table data arrives in the cycle after the row is issued.
	logic          rv_s1;
	logic [SW-1:0] rk_s1;
	row_t          reach_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= cmd.reach_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reach_issue) begin
			rk_s1 <= step_q;
		end
	end

	assign reach_data = sym_cur & act & {MAX_STATES{symc_ok}};

	// Per-state cells: epsilon row, closure row, reach and result accumulators.
	row_t eps_q   [MAX_STATES];
	row_t cl_q    [MAX_STATES];
	row_t upd     [MAX_STATES];
	row_t reach_q [MAX_STATES];
	row_t fin_q;
	row_t fin_new;

	genvar g;
	generate
		for (g = 0; g < MAX_STATES; g++) begin : g_cell
			localparam int   NXT    = (g + 1) % MAX_STATES;
			localparam row_t ROW_ID = ONE << g;

			assign act[g] = EW'(g) < ns_eff;

			// Warshall update against the pivot row held in cell zero.
			assign upd[g] = cl_q[g][step_q] ? (cl_q[g] | cl_q[0]) : cl_q[g];

			// Final flag after propagation through the closure.
			assign fin_new[g] = act[g] ? |(cl_q[g] & fin_q & act) : fin_q[g];

			// Epsilon moves out of this state.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					eps_q[g] <= '0;
				end else if (cmd.clear_tables) begin
					eps_q[g] <= '0;
				end else if (cmd.eps_wr && from_q == SW'(g)) begin
					eps_q[g] <= eps_q[g] | (ONE << to_q);
				end
			end

			// Closure rows rotate by one cell per step so the pivot sits in cell zero.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cl_q[g] <= '0;
				end else if (cmd.clear_tables) begin
					cl_q[g] <= '0;
				end else if (cmd.warsh_init) begin
					cl_q[g] <= act[g] ? ((eps_q[g] & act) | ROW_ID) : '0;
				end else if (cmd.warsh_step) begin
					cl_q[g] <= upd[NXT];
				end else if (cmd.clos_step) begin
					cl_q[g] <= cl_q[NXT];
				end
			end

			// Targets reachable on the current symbol from this state's closure.
			always_ff @(posedge clk) begin
				if (cmd.acc_clr) begin
					reach_q[g] <= '0;
				end else if (rv_s1 && cl_q[g][rk_s1]) begin
					reach_q[g] <= reach_q[g] | reach_data;
				end
			end

			// Closure of the reached set, then shifted out toward the table.
			always_ff @(posedge clk) begin
				if (cmd.acc_clr) begin
					res_q[g] <= '0;
				end else if (cmd.clos_step) begin
					if (reach_q[g][step_q]) begin
						res_q[g] <= res_q[g] | cl_q[0];
					end
				end else if (cmd.res_write) begin
					if (g == MAX_STATES - 1) begin
						res_q[g] <= '0;
					end else begin
						res_q[g] <= res_q[NXT];
					end
				end
			end
		end
	endgenerate

	// Final flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= '0;
		end else if (cmd.clear_tables) begin
			fin_q <= '0;
		end else if (cmd.fin_wr) begin
			fin_q <= fin_q | (ONE << from_q);
		end else if (cmd.fin_prop) begin
			fin_q <= fin_new;
		end
	end

	// Result of the item being worked on.
	logic rslt_status_q, rslt_fin_q;
	row_t rslt_tgt_q, rslt_cl_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rslt_status_q <= 1'b0;
			rslt_tgt_q    <= '0;
			rslt_cl_q     <= '0;
			rslt_fin_q    <= 1'b0;
		end else if (cmd.set_err) begin
			rslt_status_q <= 1'b1;
		end else if (cmd.q_capture) begin
			rslt_tgt_q <= computed_q ? res_rdata : '0;
			rslt_cl_q  <= cl_q[from_q];
			rslt_fin_q <= fin_q[from_q];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status       <= rslt_status_q;
			target_mask  <= rslt_tgt_q;
			closure_mask <= rslt_cl_q;
			is_final     <= rslt_fin_q;
		end
	end

endmodule

### rtl/core/nfa_epsilon_removal_engine.sv
// Each accepted item passes through decode and a finish state; clear, add epsilon move, mark
// final and errors need no more, add symbol move and query add a registered table read. Compute
// (N = MAX_STATES, S = MAX_SYMBOLS) runs a row-serial Warshall closure sweep over N rows, final
// flag propagation, then for each of S symbols a reach, closure and write sweep of one table
// row per cycle. One item is in work at a time; the next is taken while a result waits on
// stall. Reset clears all tables and sets 16 states, 4 symbols.
module nfa_epsilon_removal_engine
	import nfaer_pkg::*;
#(
	parameter int MAX_STATES  = MAX_STATES_DEF,
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              in_valid,
	output logic                                              in_stall,
	input  logic [MODE_W-1:0]                                 mode,
	input  logic [$clog2(MAX_STATES)-1:0]                     from_state,
	input  logic [((MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1)-1:0] symbol,
	input  logic [$clog2(MAX_STATES)-1:0]                     to_state,
	output logic                                              out_valid,
	input  logic                                              out_stall,
	output logic                                              status,
	output logic [MAX_STATES-1:0]                             target_mask,
	output logic [MAX_STATES-1:0]                             closure_mask,
	output logic                                              is_final,
	input  logic                                              cfg_we,
	input  logic [CFG_IDX_W-1:0]                              cfg_index,
	input  logic [CFG_W-1:0]                                  cfg_data
);

	nfaer_cmd_t cmd;
	nfaer_sts_t sts;

	// Sequencer.
	nfaer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Tables, closure cells and result register.
	nfaer_dp #(
		.MAX_STATES  (MAX_STATES),
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mode         (mode),
		.from_state   (from_state),
		.symbol       (symbol),
		.to_state     (to_state),
		.status       (status),
		.target_mask  (target_mask),
		.closure_mask (closure_mask),
		.is_final     (is_final)
	);

endmodule

### tb/sv/nfa_epsilon_removal_engine_test.sv
module nfa_epsilon_removal_engine_test;
	timeunit 1ns;
	timeprecision 1ps;
	import nfaer_pkg::*;

	localparam int N_ST  = MAX_STATES_DEF;
	localparam int N_SYM = MAX_SYMBOLS_DEF;
	localparam int ST_W  = $clog2(N_ST);
	localparam int SYM_W = (N_SYM > 1) ? $clog2(N_SYM) : 1;

	// The two mode codes that the block does not define.
	localparam logic [MODE_W-1:0] MODE_UNUSED_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_UNUSED_B = 3'd7;

	localparam int RANDOM_ITEMS   = 850;
	localparam int PHASES         = 8;
	localparam int IDLE_PERCENT   = 16;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int SETTLE_CYCLES  = 8;

	// Keeps a copy of the automaton tables and the expected answers in arrival order.
	class nfa_table_scoreboard;
		typedef struct packed {
			logic            status;
			logic [N_ST-1:0] target;
			logic [N_ST-1:0] closure;
			logic            final_bit;
		} answer_t;

		logic [N_ST-1:0] sym_moves [N_ST*N_SYM];
		logic [N_ST-1:0] eps_moves [N_ST];
		logic [N_ST-1:0] finals;
		logic [N_ST-1:0] closures [N_ST];
		logic [N_ST-1:0] new_moves [N_ST*N_SYM];
		logic [NS_W-1:0] states_reg;
		logic [NA_W-1:0] symbols_reg;
		answer_t pending_answers[$];
		int n_items;
		int n_results;
		int n_fail;
		int n_computes;
		int n_query_hits;
		int n_rejects;

		function void wipe_tables();
			foreach (sym_moves[i]) sym_moves[i] = '0;
			foreach (eps_moves[i]) eps_moves[i] = '0;
			foreach (closures[i]) closures[i] = '0;
			foreach (new_moves[i]) new_moves[i] = '0;
			finals = '0;
		endfunction

		function void power_up();
			states_reg = NS_W'(N_ST);
			symbols_reg = NA_W'(N_SYM);
			wipe_tables();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == CFG_NUM_STATES)
				states_reg = val[NS_W-1:0];
			else if (idx == CFG_NUM_SYMBOLS)
				symbols_reg = val[NA_W-1:0];
		endfunction

		// Counts above the table size behave as the table size.
		function int live_states();
			return (states_reg > N_ST) ? N_ST : int'(states_reg);
		endfunction

		function int live_symbols();
			return (symbols_reg > N_SYM) ? N_SYM : int'(symbols_reg);
		endfunction

		function int pending();
			return pending_answers.size();
		endfunction

		// Forms the epsilon closures, propagates final flags and builds the new move table.
		function void remove_epsilon();
			int ns;
			int na;
			int i;
			int j;
			int k;
			logic [N_ST-1:0] act;
			logic [N_ST-1:0] kept;
			logic [N_ST-1:0] span;
			logic [N_ST-1:0] prev;
			logic [N_ST-1:0] reach;
			logic [N_ST-1:0] res;
			ns = live_states();
			na = live_symbols();
			act = (ns >= N_ST) ? '1 : ((N_ST'(1) << ns) - N_ST'(1));
			kept = finals & ~act;

			// Grow each closure along epsilon moves until it stops changing.
			for (i = 0; i < N_ST; i++) begin
				span = '0;
				if (i < ns) begin
					span[i] = 1'b1;
					do begin
						prev = span;
						for (k = 0; k < ns; k++)
							if (span[k])
								span |= eps_moves[k] & act;
					end while (span != prev);
					if ((span & finals & act) != '0)
						kept[i] = 1'b1;
				end
				closures[i] = span;
			end

			// Symbol step from the closure, then the closure of every state reached.
			for (i = 0; i < N_ST; i++) begin
				for (j = 0; j < N_SYM; j++) begin
					reach = '0;
					res = '0;
					if (i < ns && j < na) begin
						for (k = 0; k < ns; k++)
							if (closures[i][k])
								reach |= sym_moves[k*N_SYM + j] & act;
						for (k = 0; k < ns; k++)
							if (reach[k])
								res |= closures[k];
					end
					new_moves[i*N_SYM + j] = res;
				end
			end
			finals = kept;
		endfunction

		// Applies one accepted item to the tables and queues the answer it must produce.
		function void note_item(logic [MODE_W-1:0] op, logic [ST_W-1:0] src,
				logic [SYM_W-1:0] sym, logic [ST_W-1:0] dst);
			answer_t ans;
			int ns;
			int na;
			ns = live_states();
			na = live_symbols();
			ans = '0;
			case (op)
				MODE_CLEAR: begin
					wipe_tables();
				end
				MODE_ADD_SYM: begin
					if (src < ns && dst < ns && sym < na)
						sym_moves[src*N_SYM + sym][dst] = 1'b1;
					else
						ans.status = 1'b1;
				end
				MODE_ADD_EPS: begin
					if (src < ns && dst < ns)
						eps_moves[src][dst] = 1'b1;
					else
						ans.status = 1'b1;
				end
				MODE_FINAL: begin
					if (src < ns)
						finals[src] = 1'b1;
					else
						ans.status = 1'b1;
				end
				MODE_COMPUTE: begin
					remove_epsilon();
					n_computes++;
				end
				MODE_QUERY: begin
					if (src < ns && sym < na) begin
						ans.target = new_moves[src*N_SYM + sym];
						ans.closure = closures[src];
						ans.final_bit = finals[src];
						n_query_hits++;
					end else begin
						ans.status = 1'b1;
					end
				end
				default: begin
					ans.status = 1'b1;
				end
			endcase
			if (ans.status)
				n_rejects++;
			pending_answers.push_back(ans);
			n_items++;
		endfunction

		function void match_field(string name, logic [N_ST-1:0] want, logic [N_ST-1:0] got);
			if (got !== want) begin
				$display("%0t ns: %s mismatch on result %0d: expected %h, actual %h",
					$time, name, n_results, want, got);
				n_fail++;
			end
		endfunction

		// Compares one result with the oldest expected answer.
		function void check_result(logic st, logic [N_ST-1:0] tgt, logic [N_ST-1:0] clo,
				logic fin);
			answer_t want;
			n_results++;
			if (pending_answers.size() == 0) begin
				$display("%0t ns: result with no item waiting: status %0b target %h closure %h final %0b",
					$time, st, tgt, clo, fin);
				n_fail++;
				return;
			end
			want = pending_answers.pop_front();
			match_field("status", N_ST'(want.status), N_ST'(st));
			match_field("target_mask", want.target, tgt);
			match_field("closure_mask", want.closure, clo);
			match_field("is_final", N_ST'(want.final_bit), N_ST'(fin));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [MODE_W-1:0]    mode;
	logic [ST_W-1:0]      from_state;
	logic [SYM_W-1:0]     symbol;
	logic [ST_W-1:0]      to_state;
	logic                 out_valid;
	logic                 out_stall;
	logic                 status;
	logic [N_ST-1:0]      target_mask;
	logic [N_ST-1:0]      closure_mask;
	logic                 is_final;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	nfa_table_scoreboard sb;
	bit calm;
	bit squeeze_armed;
	bit squeeze_done;
	int hold_left;
	int settings_used;

	nfa_epsilon_removal_engine uut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: random stalls, none while calm, and one long hold-off to fill the block.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (squeeze_armed && !squeeze_done) begin
				squeeze_done = 1'b1;
				hold_left = SQUEEZE_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
			end
		end
	end

	// Both handshakes are observed at the clock edge, with values from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(status, target_mask, closure_mask, is_final);
			if (in_valid && !in_stall)
				sb.note_item(mode, from_state, symbol, to_state);
		end
	end

	initial begin
		#20_000_000;
		$display("Run stopped: the block stopped making progress.");
		$display("== FAIL ==");
		$finish;
	end

	// Offers one item, sometimes after a gap, and returns at the edge that accepts it.
	task automatic send_item(input logic [MODE_W-1:0] op, input logic [ST_W-1:0] src,
			input logic [SYM_W-1:0] sym, input logic [ST_W-1:0] dst);
		if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		from_state <= src;
		symbol <= sym;
		to_state <= dst;
		do @(posedge clk); while (in_stall);
	endtask

	// Stops offering items and waits until every answer is in and the block is quiet.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_counts(input logic [CFG_W-1:0] ns_val, input logic [CFG_W-1:0] na_val);
		cfg_we <= 1'b1;
		cfg_index <= CFG_NUM_STATES;
		cfg_data <= ns_val;
		@(posedge clk);
		sb.set_reg(CFG_NUM_STATES, ns_val);
		cfg_index <= CFG_NUM_SYMBOLS;
		cfg_data <= na_val;
		@(posedge clk);
		sb.set_reg(CFG_NUM_SYMBOLS, na_val);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [ST_W-1:0] pick_state(int ns);
		return (ns > 0) ? ST_W'($urandom_range(ns - 1)) : ST_W'($urandom);
	endfunction

	function automatic logic [SYM_W-1:0] pick_symbol(int na);
		return (na > 0) ? SYM_W'($urandom_range(na - 1)) : SYM_W'($urandom);
	endfunction

	task automatic send_noise();
		send_item(MODE_W'($urandom_range(1, 7)), ST_W'($urandom), SYM_W'($urandom),
			ST_W'($urandom));
	endtask

	// One well-formed session: build an automaton in range, compute, then ask about it.
	task automatic build_and_query();
		int ns;
		int na;
		int n_edges;
		int n_asks;
		int pick;
		ns = sb.live_states();
		na = sb.live_symbols();
		n_edges = $urandom_range(1, (2 * ns + 1 > 20) ? 20 : 2 * ns + 1);
		n_asks = $urandom_range(2, 8);
		if ($urandom_range(3) != 0)
			send_item(MODE_CLEAR, ST_W'($urandom), SYM_W'($urandom), ST_W'($urandom));
		for (int e = 0; e < n_edges; e++) begin
			pick = $urandom_range(99);
			if (pick < 8)
				send_noise();
			else if (pick < 55)
				send_item(MODE_ADD_SYM, pick_state(ns), pick_symbol(na), pick_state(ns));
			else if (pick < 88)
				send_item(MODE_ADD_EPS, pick_state(ns), SYM_W'($urandom), pick_state(ns));
			else
				send_item(MODE_FINAL, pick_state(ns), SYM_W'($urandom), ST_W'($urandom));
		end
		send_item(MODE_COMPUTE, ST_W'($urandom), SYM_W'($urandom), ST_W'($urandom));
		for (int q = 0; q < n_asks; q++) begin
			if ($urandom_range(9) == 0)
				send_item(MODE_QUERY, ST_W'($urandom), SYM_W'($urandom), ST_W'($urandom));
			else
				send_item(MODE_QUERY, pick_state(ns), pick_symbol(na), ST_W'($urandom));
		end
	endtask

	initial begin
		int quota;
		int target_end;
		logic [CFG_W-1:0] ns_raw;
		logic [CFG_W-1:0] na_raw;
		sb = new;
		sb.power_up();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_CLEAR;
		from_state <= '0;
		symbol <= '0;
		to_state <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_NUM_STATES;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extreme states and symbols, an epsilon loop through 0, 1 and 15, and a
		// query before compute that must still see empty tables.
		send_item(MODE_QUERY, 0, 0, 0);
		send_item(MODE_ADD_SYM, 0, 0, 15);
		send_item(MODE_ADD_SYM, 15, 3, 0);
		send_item(MODE_ADD_SYM, 1, 3, 7);
		send_item(MODE_ADD_EPS, 0, 3, 1);
		send_item(MODE_ADD_EPS, 1, 0, 15);
		send_item(MODE_ADD_EPS, 15, 0, 0);
		send_item(MODE_FINAL, 15, 3, 15);
		send_item(MODE_QUERY, 0, 0, 0);
		send_item(MODE_COMPUTE, 0, 0, 0);
		send_item(MODE_QUERY, 0, 0, 0);
		send_item(MODE_QUERY, 15, 3, 0);
		send_item(MODE_QUERY, 7, 2, 0);
		send_item(MODE_UNUSED_A, 15, 3, 15);
		send_item(MODE_UNUSED_B, 15, 3, 15);
		// A second compute must not change the answers.
		send_item(MODE_COMPUTE, 15, 3, 15);
		send_item(MODE_QUERY, 1, 3, 0);
		send_item(MODE_CLEAR, 15, 3, 15);
		send_item(MODE_QUERY, 0, 0, 0);
		send_item(MODE_FINAL, 12, 0, 0);
		send_item(MODE_ADD_SYM, 12, 1, 3);

		// Zero counts: everything is out of range and compute leaves empty tables,
		// but the final flag of state 12 survives.
		settle();
		write_counts(5'd0, 5'd0);
		send_item(MODE_ADD_SYM, 0, 0, 0);
		send_item(MODE_ADD_EPS, 0, 0, 0);
		send_item(MODE_FINAL, 0, 0, 0);
		send_item(MODE_QUERY, 0, 0, 0);
		send_item(MODE_COMPUTE, 0, 0, 0);

		// Counts above the table size act as full size.
		settle();
		write_counts(5'd31, 5'd30);
		send_item(MODE_QUERY, 12, 1, 0);

		// Random sessions under a series of register settings.
		quota = RANDOM_ITEMS / PHASES;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					ns_raw = 5'd16;
					na_raw = 5'd4;
				end
				1: begin
					ns_raw = 5'd1;
					na_raw = 5'd1;
				end
				2: begin
					ns_raw = 5'd6;
					na_raw = 5'd2;
				end
				3: begin
					ns_raw = 5'd2;
					na_raw = 5'd3;
				end
				4: begin
					ns_raw = 5'd17;
					na_raw = 5'd5;
				end
				7: begin
					ns_raw = 5'd9;
					na_raw = 5'd4;
				end
				default: begin
					ns_raw = CFG_W'($urandom_range(1, N_ST));
					na_raw = CFG_W'($urandom_range(1, N_SYM));
				end
			endcase
			settle();
			write_counts(ns_raw, na_raw);
			calm = (phase == 3);
			if (phase == 2)
				squeeze_armed = 1'b1;
			target_end = sb.n_items + quota;
			// Tables left from the previous setting, computed under the new counts.
			if ($urandom_range(1) == 0)
				send_item(MODE_COMPUTE, ST_W'($urandom), SYM_W'($urandom), ST_W'($urandom));
			while (sb.n_items < target_end)
				build_and_query();
		end

		settle();
		$display("Checked %0d results from %0d items: %0d computes, %0d answered queries, %0d rejected.",
			sb.n_results, sb.n_items, sb.n_computes, sb.n_query_hits, sb.n_rejects);
		$display("Used %0d register settings, with zero counts, counts beyond the table and one long output stall.",
			settings_used);
		if (sb.n_fail == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
